@@ rtl/imu_fca_pkg.sv @@
// Shared types, constants and the CRC byte step for the IMU frame checker.
package imu_fca_pkg;

    localparam int FRAME_BYTES_DEF = 41;
    localparam int MAX_PAYLOAD_DEF = 35;

    // Capture fields end at this byte; a shorter frame always fails.
    localparam int FIELDS_END = 36;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [4:0] WARMUP_CAP = 5'd18;

    localparam logic signed [16:0] YAW_HALF   = 17'sd1800;
    localparam logic signed [16:0] PITCH_HALF = 17'sd18000;
    localparam logic signed [27:0] YAW_FULL   = 28'sd3600;
    localparam logic signed [31:0] PITCH_FULL = 32'sd36000;

    localparam logic signed [15:0] PREV_YAW_INIT   = 16'sd1800;
    localparam logic signed [15:0] PREV_PITCH_INIT = 16'sd18000;
    localparam logic signed [15:0] TURN_MAX        = 16'sh7FFF;
    localparam logic signed [15:0] TURN_MIN        = 16'sh8000;

    // One byte into a CRC-16, MSB first, no final xor.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // CRC state after the two fixed header constants.
    localparam logic [15:0] CRC_SEED = crc_feed(crc_feed(16'h0000, 8'h5A), 8'hA5);

    // Frame summary handed from the deframer to the unwrapper.
    typedef struct packed {
        logic               ok;
        logic signed [15:0] yaw_raw;
        logic signed [15:0] pitch_raw;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] pitch_rate;
    } frame_t;

    // One result item.
    typedef struct packed {
        logic               crc_ok;
        logic signed [27:0] yaw_angle;
        logic signed [31:0] pitch_angle;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] yaw_turns;
        logic signed [15:0] pitch_turns;
        logic [15:0]        frames_seen;
    } result_t;

endpackage

@@ rtl/imu_frame_check_and_angle_unwrap.sv @@
// Top level: IMU frame CRC check and yaw/pitch angle unwrap.
//
//   channel   direction   handshake          payload
//   s_        in          s_valid/s_ready    s_op, s_rx_byte
//   m_        out         m_valid/m_ready    m_crc_ok .. m_frames_seen
//   apb       in          psel/penable       paddr, pwdata, prdata
//
// One item per cycle sustained while no end-of-frame item is held: an item
// lands in the input register, then one pass of logic updates the frame
// state (one CRC byte step, field capture) or, for an end-of-frame item,
// loads the result register that drives m_valid, so an end-of-frame item
// passes the input register and then the result register.
// Byte items never stall; an end-of-frame item holds in the input register
// only while the previous result still waits for m_ready.
// Reset (aresetn low, synchronous) clears frame state and counters and sets
// warmup_frames to 12.
module imu_frame_check_and_angle_unwrap
    import imu_fca_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [7:0]         s_rx_byte,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_crc_ok,
    output logic signed [27:0] m_yaw_angle,
    output logic signed [31:0] m_pitch_angle,
    output logic signed [15:0] m_yaw_rate,
    output logic signed [15:0] m_pitch_rate,
    output logic signed [15:0] m_yaw_turns,
    output logic signed [15:0] m_pitch_turns,
    output logic [15:0]        m_frames_seen,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [4:0] WARMUP_RESET = 5'd12;

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       m_valid_reg;
    result_t    m_data_reg;
    logic [4:0] warmup_reg;

    logic       advance;
    logic       byte_en;
    logic       eof_en;
    frame_t     frame;
    result_t    res;

    // The single register sits at word 0; byte offset bits are ignored.
    assign pready = 1'b1;
    assign prdata = {27'b0, warmup_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_reg <= WARMUP_RESET;
        end else if (psel && penable && pwrite) begin
            warmup_reg <= pwdata[4:0];
        end
    end

    // Hold an end-of-frame item while the previous result is not yet taken.
    assign advance = in_valid_reg && !(in_op_reg && m_valid_reg && !m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign byte_en = advance && !in_op_reg;
    assign eof_en  = advance && in_op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_op;
            in_byte_reg <= s_rx_byte;
        end
    end

    imu_fca_deframe #(
        .FRAME_BYTES (FRAME_BYTES),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_deframe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .rx_byte (in_byte_reg),
        .eof_en  (eof_en),
        .frame   (frame)
    );

    imu_fca_unwrap u_unwrap (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .eof_en        (eof_en),
        .frame         (frame),
        .warmup_frames (warmup_reg),
        .res           (res)
    );

    // Result register: load on end of frame, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eof_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eof_en) begin
            m_data_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_crc_ok      = m_data_reg.crc_ok;
    assign m_yaw_angle   = m_data_reg.yaw_angle;
    assign m_pitch_angle = m_data_reg.pitch_angle;
    assign m_yaw_rate    = m_data_reg.yaw_rate;
    assign m_pitch_rate  = m_data_reg.pitch_rate;
    assign m_yaw_turns   = m_data_reg.yaw_turns;
    assign m_pitch_turns = m_data_reg.pitch_turns;
    assign m_frames_seen = m_data_reg.frames_seen;

    // The input side stalls only behind a blocked end-of-frame item.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_op_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked end-of-frame item");

    // A byte item in the input register always moves on.
    a_byte_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_op_reg) |-> advance)
        else $error("byte item held in input register");

    // A new result appears only after an end-of-frame item advanced.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(eof_en))
        else $error("result valid without end-of-frame item");

endmodule

@@ rtl/imu_fca_deframe.sv @@
// Byte position tracking, running CRC, field capture and frame check.
module imu_fca_deframe
    import imu_fca_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    input  logic       eof_en,
    output frame_t     frame
);

    localparam int POS_W = $clog2(FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_FIELDS = POS_W'(FIELDS_END);
    localparam logic [15:0]      LEN_MAX    = 16'(MAX_PAYLOAD);

    logic [POS_W-1:0] pos_reg;
    logic [15:0]      len_reg;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_rx_reg;
    logic [15:0]      pitch_rate_reg;
    logic [15:0]      yaw_rate_reg;
    logic [15:0]      pitch_raw_reg;
    logic [15:0]      yaw_raw_reg;

    logic [16:0] pos_ext;
    logic        in_payload;
    logic        take;

    assign pos_ext    = 17'(pos_reg);
    assign in_payload = (pos_ext >= 17'd6) && ((pos_ext - 17'd6) < {1'b0, len_reg});
    // Bytes past the frame limit are dropped.
    assign take       = byte_en && (pos_reg < POS_LAST);

    assign frame.ok = (len_reg <= LEN_MAX) && (pos_reg >= POS_FIELDS)
                   && (pos_ext >= (17'd6 + {1'b0, len_reg})) && (crc_reg == crc_rx_reg);
    assign frame.yaw_raw    = yaw_raw_reg;
    assign frame.pitch_raw  = pitch_raw_reg;
    assign frame.yaw_rate   = yaw_rate_reg;
    assign frame.pitch_rate = pitch_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || eof_en) begin
            pos_reg        <= '0;
            len_reg        <= '0;
            crc_reg        <= '0;
            crc_rx_reg     <= '0;
            pitch_rate_reg <= '0;
            yaw_rate_reg   <= '0;
            pitch_raw_reg  <= '0;
            yaw_raw_reg    <= '0;
        end else if (take) begin
            pos_reg <= pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(2)) begin
                crc_reg <= crc_feed(CRC_SEED, rx_byte);
                len_reg <= {8'h00, rx_byte};
            end else if (pos_reg == POS_W'(3)) begin
                crc_reg <= crc_feed(crc_reg, rx_byte);
                len_reg <= {rx_byte, len_reg[7:0]};
            end else if (pos_reg == POS_W'(4)) begin
                crc_rx_reg <= {8'h00, rx_byte};
            end else if (pos_reg == POS_W'(5)) begin
                crc_rx_reg <= {rx_byte, crc_rx_reg[7:0]};
            end else if (in_payload) begin
                crc_reg <= crc_feed(crc_reg, rx_byte);
            end
            if (pos_reg == POS_W'(16)) pitch_rate_reg[7:0]  <= rx_byte;
            if (pos_reg == POS_W'(17)) pitch_rate_reg[15:8] <= rx_byte;
            if (pos_reg == POS_W'(20)) yaw_rate_reg[7:0]    <= rx_byte;
            if (pos_reg == POS_W'(21)) yaw_rate_reg[15:8]   <= rx_byte;
            if (pos_reg == POS_W'(32)) pitch_raw_reg[7:0]   <= rx_byte;
            if (pos_reg == POS_W'(33)) pitch_raw_reg[15:8]  <= rx_byte;
            if (pos_reg == POS_W'(34)) yaw_raw_reg[7:0]     <= rx_byte;
            if (pos_reg == POS_W'(35)) yaw_raw_reg[15:8]    <= rx_byte;
        end
    end

endmodule

@@ rtl/imu_fca_unwrap.sv @@
// Turn counters, warm-up count, frame count and held angles and rates.
module imu_fca_unwrap
    import imu_fca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       eof_en,
    input  frame_t     frame,
    input  logic [4:0] warmup_frames,
    output result_t    res
);

    logic signed [15:0] prev_yaw_reg, prev_pitch_reg;
    logic signed [15:0] yaw_turn_reg, pitch_turn_reg;
    // Running 3600*turns and 36000*turns, so no multiplier is needed.
    logic signed [27:0] yaw_prod_reg;
    logic signed [31:0] pitch_prod_reg;
    logic [4:0]         warm_reg;
    logic [15:0]        frame_cnt_reg;
    logic signed [27:0] yaw_angle_reg;
    logic signed [31:0] pitch_angle_reg;
    logic signed [15:0] yaw_rate_reg, pitch_rate_reg;

    logic [4:0]         warm_next;
    logic [15:0]        frame_cnt_next;
    logic               force_zero;
    logic signed [16:0] yaw_diff, pitch_diff;
    logic signed [15:0] yaw_turn_next, pitch_turn_next;
    logic signed [27:0] yaw_prod_next;
    logic signed [31:0] pitch_prod_next;
    logic signed [27:0] yaw_angle_next;
    logic signed [31:0] pitch_angle_next;

    always_comb begin
        warm_next      = (warm_reg < WARMUP_CAP) ? warm_reg + 5'd1 : warm_reg;
        frame_cnt_next = frame_cnt_reg + 16'd1;
        force_zero     = warm_next < warmup_frames;

        yaw_diff   = {frame.yaw_raw[15], frame.yaw_raw} - {prev_yaw_reg[15], prev_yaw_reg};
        pitch_diff = {frame.pitch_raw[15], frame.pitch_raw}
                   - {prev_pitch_reg[15], prev_pitch_reg};

        yaw_turn_next = yaw_turn_reg;
        yaw_prod_next = yaw_prod_reg;
        if (yaw_diff > YAW_HALF && yaw_turn_reg != TURN_MAX) begin
            yaw_turn_next = yaw_turn_reg + 16'sd1;
            yaw_prod_next = yaw_prod_reg + YAW_FULL;
        end else if (yaw_diff < -YAW_HALF && yaw_turn_reg != TURN_MIN) begin
            yaw_turn_next = yaw_turn_reg - 16'sd1;
            yaw_prod_next = yaw_prod_reg - YAW_FULL;
        end

        pitch_turn_next = pitch_turn_reg;
        pitch_prod_next = pitch_prod_reg;
        if (pitch_diff > PITCH_HALF && pitch_turn_reg != TURN_MAX) begin
            pitch_turn_next = pitch_turn_reg + 16'sd1;
            pitch_prod_next = pitch_prod_reg + PITCH_FULL;
        end else if (pitch_diff < -PITCH_HALF && pitch_turn_reg != TURN_MIN) begin
            pitch_turn_next = pitch_turn_reg - 16'sd1;
            pitch_prod_next = pitch_prod_reg - PITCH_FULL;
        end

        if (force_zero) begin
            yaw_turn_next   = '0;
            yaw_prod_next   = '0;
            pitch_turn_next = '0;
            pitch_prod_next = '0;
        end

        yaw_angle_next   = 28'(frame.yaw_raw) - yaw_prod_next;
        pitch_angle_next = 32'(frame.pitch_raw) - pitch_prod_next;

        res.crc_ok      = frame.ok;
        res.frames_seen = frame_cnt_next;
        if (frame.ok) begin
            res.yaw_angle   = yaw_angle_next;
            res.pitch_angle = pitch_angle_next;
            res.yaw_rate    = frame.yaw_rate;
            res.pitch_rate  = frame.pitch_rate;
            res.yaw_turns   = yaw_turn_next;
            res.pitch_turns = pitch_turn_next;
        end else begin
            res.yaw_angle   = yaw_angle_reg;
            res.pitch_angle = pitch_angle_reg;
            res.yaw_rate    = yaw_rate_reg;
            res.pitch_rate  = pitch_rate_reg;
            res.yaw_turns   = yaw_turn_reg;
            res.pitch_turns = pitch_turn_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_yaw_reg    <= PREV_YAW_INIT;
            prev_pitch_reg  <= PREV_PITCH_INIT;
            yaw_turn_reg    <= '0;
            pitch_turn_reg  <= '0;
            yaw_prod_reg    <= '0;
            pitch_prod_reg  <= '0;
            warm_reg        <= '0;
            frame_cnt_reg   <= '0;
            yaw_angle_reg   <= '0;
            pitch_angle_reg <= '0;
            yaw_rate_reg    <= '0;
            pitch_rate_reg  <= '0;
        end else if (eof_en) begin
            warm_reg      <= warm_next;
            frame_cnt_reg <= frame_cnt_next;
            if (frame.ok) begin
                prev_yaw_reg    <= frame.yaw_raw;
                prev_pitch_reg  <= frame.pitch_raw;
                yaw_turn_reg    <= yaw_turn_next;
                pitch_turn_reg  <= pitch_turn_next;
                yaw_prod_reg    <= yaw_prod_next;
                pitch_prod_reg  <= pitch_prod_next;
                yaw_angle_reg   <= yaw_angle_next;
                pitch_angle_reg <= pitch_angle_next;
                yaw_rate_reg    <= frame.yaw_rate;
                pitch_rate_reg  <= frame.pitch_rate;
            end
        end
    end

endmodule

@@ bench/tb_imu_frame_check_and_angle_unwrap.sv @@
// Self-checking testbench for the IMU frame CRC check and angle unwrap block.
`timescale 1ns / 1ps

module tb_imu_frame_check_and_angle_unwrap;
    import imu_fca_pkg::*;

    // Item codes on s_op.
    typedef enum logic {
        OP_BYTE     = 1'b0,
        OP_LINE_IDLE = 1'b1
    } op_e;

    // Register addresses (byte addressed, one 32-bit slot each).
    localparam logic [1:0] REG_WARMUP_FRAMES = 2'd0;

    localparam logic [7:0] HDR_SYNC0 = 8'h5A;
    localparam logic [7:0] HDR_SYNC1 = 8'hA5;

    localparam int FRAME_BUF_LEN = 50;
    localparam int ITEM_TARGET   = 1450;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 200000;

    // Clock, reset and block ports.
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_crc_ok;
    logic signed [27:0] m_yaw_angle;
    logic signed [31:0] m_pitch_angle;
    logic signed [15:0] m_yaw_rate;
    logic signed [15:0] m_pitch_rate;
    logic signed [15:0] m_yaw_turns;
    logic signed [15:0] m_pitch_turns;
    logic [15:0]        m_frames_seen;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [1:0]         paddr = 2'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    imu_frame_check_and_angle_unwrap i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_crc_ok      (m_crc_ok),
        .m_yaw_angle   (m_yaw_angle),
        .m_pitch_angle (m_pitch_angle),
        .m_yaw_rate    (m_yaw_rate),
        .m_pitch_rate  (m_pitch_rate),
        .m_yaw_turns   (m_yaw_turns),
        .m_pitch_turns (m_pitch_turns),
        .m_frames_seen (m_frames_seen),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Bookkeeping.
    int error_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int sender_idle_pct = 14;
    int rcv_idle_pct = 62;
    bit hold_req = 1'b0;
    int hold_left = 0;

    // Results the block owes us, oldest first.
    result_t pending_frame_results[$];

    // Shadow of the configuration register.
    logic [4:0] cfg_warmup = 5'd12;

    // Shadow of the per-frame state; cleared at every end of frame.
    int          fr_pos = 0;
    logic [15:0] fr_len = '0;
    logic [15:0] fr_crc = '0;
    logic [15:0] fr_crc_rx = '0;
    logic [15:0] fr_prate = '0;
    logic [15:0] fr_yrate = '0;
    logic [15:0] fr_praw = '0;
    logic [15:0] fr_yraw = '0;

    // Shadow of the unwrap state that survives across frames.
    int                 last_yaw = 1800;
    int                 last_pitch = 18000;
    int                 yaw_turns = 0;
    int                 pitch_turns = 0;
    int                 warm_count = 0;
    logic [15:0]        frames_count = '0;
    logic signed [27:0] held_yaw_angle = '0;
    logic signed [31:0] held_pitch_angle = '0;
    logic signed [15:0] held_yaw_rate = '0;
    logic signed [15:0] held_pitch_rate = '0;

    // Generator state for smoothly moving angles.
    int yaw_walk = 1800;
    int pitch_walk = 18000;

    // Frame under construction.
    logic [7:0] frame_buf [FRAME_BUF_LEN];

    // CRC-16, poly 0x1021, MSB first: shift one byte in.
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // CRC after the two sync constants that precede the length bytes.
    function automatic logic [15:0] crc_after_sync();
        return crc16_step(crc16_step(16'h0000, HDR_SYNC0), HDR_SYNC1);
    endfunction

    function automatic int clamp_turns(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Half-turn jump test: a jump past half a turn means the sensor wrapped.
    function automatic int half_turn_step(input int count, input int diff, input int half);
        if (diff > half) return clamp_turns(count + 1);
        if (diff < -half) return clamp_turns(count - 1);
        return count;
    endfunction

    // Advance the shadow state by one accepted item; queue a result on end of frame.
    task automatic unwrap_predict(input logic op, input logic [7:0] b);
        result_t r;
        logic    ok;
        int      yaw;
        int      pitch;
        longint  ya;
        longint  pa;
        if (op == OP_BYTE) begin
            // Drop bytes past the frame limit.
            if (fr_pos < FRAME_BYTES_DEF) begin
                if (fr_pos == 2) begin
                    fr_crc = crc16_step(crc_after_sync(), b);
                    fr_len = {8'h00, b};
                end else if (fr_pos == 3) begin
                    fr_crc = crc16_step(fr_crc, b);
                    fr_len[15:8] = b;
                end else if (fr_pos == 4) begin
                    fr_crc_rx = {8'h00, b};
                end else if (fr_pos == 5) begin
                    fr_crc_rx[15:8] = b;
                end else if (fr_pos >= 6 && (fr_pos - 6) < fr_len) begin
                    fr_crc = crc16_step(fr_crc, b);
                end
                if (fr_pos == 16) fr_prate[7:0] = b;
                if (fr_pos == 17) fr_prate[15:8] = b;
                if (fr_pos == 20) fr_yrate[7:0] = b;
                if (fr_pos == 21) fr_yrate[15:8] = b;
                if (fr_pos == 32) fr_praw[7:0] = b;
                if (fr_pos == 33) fr_praw[15:8] = b;
                if (fr_pos == 34) fr_yraw[7:0] = b;
                if (fr_pos == 35) fr_yraw[15:8] = b;
                fr_pos++;
            end
        end else begin
            frames_count = frames_count + 16'd1;
            if (warm_count < int'(WARMUP_CAP))
                warm_count++;
            // Fail short frames, over-long lengths, lengths past the bytes received and CRC mismatches.
            ok = (fr_len <= MAX_PAYLOAD_DEF) && (fr_pos >= FIELDS_END)
              && (fr_pos >= 6 + fr_len) && (fr_crc == fr_crc_rx);
            if (ok) begin
                yaw   = $signed(fr_yraw);
                pitch = $signed(fr_praw);
                yaw_turns   = half_turn_step(yaw_turns, yaw - last_yaw, int'(YAW_HALF));
                pitch_turns = half_turn_step(pitch_turns, pitch - last_pitch, int'(PITCH_HALF));
                // Hold the counters at zero while warming up.
                if (warm_count < int'(cfg_warmup)) begin
                    yaw_turns = 0;
                    pitch_turns = 0;
                end
                last_yaw   = yaw;
                last_pitch = pitch;
                ya = longint'(yaw) - longint'(YAW_FULL) * longint'(yaw_turns);
                pa = longint'(pitch) - longint'(PITCH_FULL) * longint'(pitch_turns);
                held_yaw_angle   = ya[27:0];
                held_pitch_angle = pa[31:0];
                held_yaw_rate    = fr_yrate;
                held_pitch_rate  = fr_prate;
            end
            r.crc_ok      = ok;
            r.yaw_angle   = held_yaw_angle;
            r.pitch_angle = held_pitch_angle;
            r.yaw_rate    = held_yaw_rate;
            r.pitch_rate  = held_pitch_rate;
            r.yaw_turns   = 16'(yaw_turns);
            r.pitch_turns = 16'(pitch_turns);
            r.frames_seen = frames_count;
            pending_frame_results.push_back(r);
            fr_pos    = 0;
            fr_len    = '0;
            fr_crc    = '0;
            fr_crc_rx = '0;
            fr_prate  = '0;
            fr_yrate  = '0;
            fr_praw   = '0;
            fr_yraw   = '0;
        end
    endtask

    // Offer one item, idling each cycle with the sender idle odds first; hold it until accepted.
    task automatic send_item(input logic op, input logic [7:0] b);
        @(negedge aclk);
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        unwrap_predict(op, b);
        items_sent++;
    endtask

    // Build a frame with the given fields and send its first nbytes, then the idle event.
    task automatic send_frame(input int len, input int nbytes, input logic [15:0] yaw,
                              input logic [15:0] pitch, input logic [15:0] yrate,
                              input logic [15:0] prate, input bit corrupt);
        logic [15:0] c;
        for (int i = 0; i < FRAME_BUF_LEN; i++)
            frame_buf[i] = 8'($urandom_range(0, 255));
        frame_buf[2]  = len[7:0];
        frame_buf[3]  = len[15:8];
        frame_buf[16] = prate[7:0];
        frame_buf[17] = prate[15:8];
        frame_buf[20] = yrate[7:0];
        frame_buf[21] = yrate[15:8];
        frame_buf[32] = pitch[7:0];
        frame_buf[33] = pitch[15:8];
        frame_buf[34] = yaw[7:0];
        frame_buf[35] = yaw[15:8];
        c = crc16_step(crc16_step(crc_after_sync(), len[7:0]), len[15:8]);
        for (int i = 6; i < 6 + len && i < FRAME_BUF_LEN; i++)
            c = crc16_step(c, frame_buf[i]);
        if (corrupt)
            c = c ^ (16'd1 << $urandom_range(0, 15));
        frame_buf[4] = c[7:0];
        frame_buf[5] = c[15:8];
        for (int i = 0; i < nbytes; i++)
            send_item(OP_BYTE, frame_buf[i]);
        send_item(OP_LINE_IDLE, 8'($urandom_range(0, 255)));
    endtask

    // Next yaw/pitch pair: mostly a random walk that wraps, sometimes big steps or noise.
    task automatic pick_angles(output logic [15:0] yaw, output logic [15:0] pitch);
        int mode;
        int ystep;
        int pstep;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            ystep = int'($urandom_range(0, 800)) - 400;
            pstep = int'($urandom_range(0, 8000)) - 4000;
        end else begin
            ystep = int'($urandom_range(1500, 2100));
            pstep = int'($urandom_range(15000, 21000));
            if ($urandom_range(0, 1)) ystep = -ystep;
            if ($urandom_range(0, 1)) pstep = -pstep;
        end
        yaw_walk   = ((yaw_walk + ystep) % 3600 + 3600) % 3600;
        pitch_walk = ((pitch_walk + pstep) % 36000 + 36000) % 36000;
        if (mode >= 8) begin
            yaw   = 16'($urandom);
            pitch = 16'($urandom);
        end else begin
            yaw   = 16'(yaw_walk);
            pitch = 16'(pitch_walk);
        end
    endtask

    // One random frame: mostly well formed, the rest broken or noise.
    task automatic random_frame();
        int          kind;
        int          len;
        int          nbytes;
        logic [15:0] yaw;
        logic [15:0] pitch;
        pick_angles(yaw, pitch);
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : $urandom_range(24, 35);
            nbytes = (len + 6 > 36) ? len + 6 : 36;
            // Run past the frame limit now and then.
            if ($urandom_range(0, 3) == 0)
                nbytes += $urandom_range(1, 9);
            send_frame(len, nbytes, yaw, pitch, 16'($urandom), 16'($urandom), kind >= 62);
        end else if (kind < 76) begin
            len = $urandom_range(0, 29);
            nbytes = $urandom_range(0, 35);
            send_frame(len, nbytes, yaw, pitch, 16'($urandom), 16'($urandom), 1'b0);
        end else if (kind < 82) begin
            len = $urandom_range(0, 1) ? $urandom_range(36, 255) : $urandom_range(256, 65535);
            nbytes = $urandom_range(36, 44);
            send_frame(len, nbytes, yaw, pitch, 16'($urandom), 16'($urandom), 1'b0);
        end else if (kind < 88) begin
            len = $urandom_range(31, 35);
            nbytes = $urandom_range(36, len + 5);
            send_frame(len, nbytes, yaw, pitch, 16'($urandom), 16'($urandom), 1'b0);
        end else if (kind < 94) begin
            send_item(OP_LINE_IDLE, 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 60)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            send_item(OP_LINE_IDLE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Drop valid and wait until every owed result has arrived and the pipe is empty.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_frame_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] addr, output logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change warmup_frames with the block idle, then read it back.
    task automatic set_warmup(input int value);
        logic [31:0] rd;
        wait_drained();
        apb_write(REG_WARMUP_FRAMES, 32'(value));
        cfg_warmup = 5'(value);
        apb_read(REG_WARMUP_FRAMES, rd);
        check_field("warmup_frames", cfg_warmup, rd[4:0]);
    endtask

    task automatic test_register_reset();
        logic [31:0] rd;
        apb_read(REG_WARMUP_FRAMES, rd);
        check_field("warmup_frames", cfg_warmup, rd[4:0]);
    endtask

    // Directed frames: extremes and each way a frame can fail.
    task automatic test_frame_errors();
        // Idle event with no bytes.
        send_item(OP_LINE_IDLE, 8'hFF);
        // Full-length frame with extreme field values.
        send_frame(35, 41, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        // Bad CRC.
        send_frame(35, 41, 16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 1'b1);
        // One byte short of the capture fields, CRC good.
        send_frame(29, 35, 16'd100, 16'd200, 16'd1, 16'd2, 1'b0);
        // Length just over the limit, and one with the high length byte set.
        send_frame(36, 42, 16'd300, 16'd400, 16'd3, 16'd4, 1'b0);
        send_frame(256, 41, 16'd500, 16'd600, 16'd5, 16'd6, 1'b0);
        // Length runs past the bytes received.
        send_frame(35, 39, 16'd700, 16'd800, 16'd7, 16'd8, 1'b0);
        // Overflowing frame: extra bytes are dropped and the frame still passes.
        send_frame(35, 50, 16'd900, 16'd1000, 16'd9, 16'd10, 1'b0);
        // Shortest frame that can pass: empty payload.
        send_frame(0, 36, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 1'b0);
    endtask

    // Steps of exactly half a turn and one past it, plus the 16-bit extremes.
    task automatic test_half_turn_edges();
        int yaw_seq[6]   = '{0, 1800, 3601, 1800, 32767, -32768};
        int pitch_seq[6] = '{0, 18000, -1, 18000, 32767, -32768};
        for (int i = 0; i < 6; i++)
            send_frame(35, 41, 16'(yaw_seq[i]), 16'(pitch_seq[i]),
                       16'($urandom), 16'($urandom), 1'b0);
    endtask

    // Random frames under the given idle mix; keep going until the item target is met.
    task automatic test_turn_tracking(input int s_pct, input int r_pct, input int nframes,
                                      input int item_goal);
        sender_idle_pct = s_pct;
        rcv_idle_pct    = r_pct;
        for (int n = 0; n < nframes || items_sent < item_goal; n++)
            random_frame();
    endtask

    // Hold the receiver off while frames keep coming, so the input side backs up.
    task automatic test_stall_fill();
        sender_idle_pct = 0;
        rcv_idle_pct    = 0;
        hold_req = 1'b1;
        repeat (6) random_frame();
    endtask

    // Receiver: random stalls, or a long hold-off counted here.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (rcv_idle_pct == 0) || ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frame_results.size() == 0) begin
                $error("result item with no expectation pending");
                error_count++;
            end else begin
                want = pending_frame_results.pop_front();
                check_field("crc_ok", want.crc_ok, m_crc_ok);
                check_field("yaw_angle", want.yaw_angle, m_yaw_angle);
                check_field("pitch_angle", want.pitch_angle, m_pitch_angle);
                check_field("yaw_rate", want.yaw_rate, m_yaw_rate);
                check_field("pitch_rate", want.pitch_rate, m_pitch_rate);
                check_field("yaw_turns", want.yaw_turns, m_yaw_turns);
                check_field("pitch_turns", want.pitch_turns, m_pitch_turns);
                check_field("frames_seen", want.frames_seen, m_frames_seen);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_imu_frame_check_and_angle_unwrap: done, errors");
            $finish;
        end
    end

    initial begin
        // Hold reset, then release it on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_reset();
        // Reset warm-up of 12: the first accepted frames keep the counters at zero.
        test_frame_errors();

        set_warmup(0);
        test_half_turn_edges();
        test_turn_tracking(14, 62, 8, 0);

        set_warmup(18);
        test_turn_tracking(62, 14, 8, 0);

        set_warmup($urandom_range(1, 17));
        test_stall_fill();

        set_warmup($urandom_range(0, 6));
        test_turn_tracking(0, 0, 6, ITEM_TARGET);

        wait_drained();
        if (error_count == 0)
            $display("tb_imu_frame_check_and_angle_unwrap: done, clean");
        else
            $display("tb_imu_frame_check_and_angle_unwrap: done, errors");
        $finish;
    end

endmodule

@@ imu_frame_check_and_angle_unwrap.f @@
rtl/imu_fca_pkg.sv
rtl/imu_fca_deframe.sv
rtl/imu_fca_unwrap.sv
rtl/imu_frame_check_and_angle_unwrap.sv
bench/tb_imu_frame_check_and_angle_unwrap.sv
